FILE: src/bmadp_pkg.sv
// ----------------------------------------------------------------------------
// bmadp_pkg - shared types and constants
// Item formats, register indexes and state encoding for the mask DP block.
// ----------------------------------------------------------------------------
package bmadp_pkg;

	localparam int MAX_ITEMS     = 1024;
	localparam int MAX_POSITIONS = 7;
	localparam int VALUE_BITS    = 30;
	localparam int TOTAL_BITS    = 41;
	localparam int IDX_W         = $clog2(MAX_ITEMS);
	localparam int CNT_W         = IDX_W + 1;
	localparam int MASK_COUNT    = 1 << MAX_POSITIONS;
	localparam int MASK_W        = MAX_POSITIONS;
	localparam int STEP_W        = $clog2(MAX_POSITIONS + 1);
	localparam int K_W           = 11;
	localparam int P_W           = 3;
	localparam int CFG_IDX_W     = 2;

	// register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_NUM_POSITIONS  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_AUDIENCE_COUNT = 2'd1;

	typedef struct packed {
		logic [VALUE_BITS-1:0] audience_strength;
		logic [VALUE_BITS-1:0] skill_0;
		logic [VALUE_BITS-1:0] skill_1;
		logic [VALUE_BITS-1:0] skill_2;
		logic [VALUE_BITS-1:0] skill_3;
		logic [VALUE_BITS-1:0] skill_4;
		logic [VALUE_BITS-1:0] skill_5;
		logic [VALUE_BITS-1:0] skill_6;
		logic                  last;
	} cand_t;

	typedef struct packed {
		logic signed [TOTAL_BITS-1:0] best_total;
		logic                         overflow;
	} res_t;

	// sorted list entry: key and arrival index
	typedef struct packed {
		logic [VALUE_BITS-1:0] key;
		logic [IDX_W-1:0]      idx;
	} ord_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SORT_RD,
		ST_SORT_KEY,
		ST_SORT_CMP,
		ST_SORT_PUT,
		ST_DP_INIT,
		ST_FETCH_ORD,
		ST_FETCH_ROW,
		ST_FETCH_SKL,
		ST_DP_RUN,
		ST_DP_DRAIN,
		ST_RES_RD,
		ST_RES_OUT
	} state_t;

endpackage

FILE: src/bitmask_assignment_with_audience_dp.sv
// ----------------------------------------------------------------------------
// bitmask_assignment_with_audience_dp - position/audience assignment by mask DP
//
// Channels: cand (valid/stall) loads one candidate item per cycle while idle.
// The item with last set starts the computation; cand_stall stays high until
// the result item has been written to the output register. res (valid/stall)
// carries one result item per set; the output register holds it while
// res_stall is high. cfg (valid/ready) is always ready; write it while idle.
// Steps after the last item, in state order:
//   sort    : insertion sort over one list memory (one read and one write a
//             cycle); SORT_RD, SORT_KEY fetch an item, one compare a cycle
//   DP      : DP_INIT set-up, then per candidate FETCH_ORD, FETCH_ROW,
//             FETCH_SKL, DP_RUN over each mask and step, then DP_DRAIN; one
//             row-memory read and one add/compare a cycle in the update unit
//   result  : RES_RD then RES_OUT, waiting for a result held in the output
// Loading runs at one item per cycle while idle. Items beyond 1024 are
// dropped and the overflow bit of the result reports it.
// Reset clears the control state, item count and overflow flag; the
// candidate and row memories hold no reset and need no clearing pass.
// ----------------------------------------------------------------------------
module bitmask_assignment_with_audience_dp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cand_valid,
	output logic                                cand_stall,
	input  bmadp_pkg::cand_t                    cand,
	output logic                                res_valid,
	input  logic                                res_stall,
	output bmadp_pkg::res_t                     res,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [bmadp_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [bmadp_pkg::K_W-1:0]           cfg_data
);

	localparam int VW = bmadp_pkg::VALUE_BITS;
	localparam int TW = bmadp_pkg::TOTAL_BITS;
	localparam int IW = bmadp_pkg::IDX_W;
	localparam int CW = bmadp_pkg::CNT_W;
	localparam int MW = bmadp_pkg::MASK_W;
	localparam int SW = bmadp_pkg::STEP_W;
	localparam int NP = bmadp_pkg::MAX_POSITIONS;

	bmadp_pkg::state_t state_q, state_d;

	// configuration
	logic [bmadp_pkg::P_W-1:0] npos_q;
	logic [bmadp_pkg::K_W-1:0] kcnt_q;

	// memories
	logic [VW-1:0]            aud_mem [bmadp_pkg::MAX_ITEMS];
	logic [NP*VW-1:0]         skl_mem [bmadp_pkg::MAX_ITEMS];
	bmadp_pkg::ord_t          ord_mem [bmadp_pkg::MAX_ITEMS];
	logic [TW-1:0]            row_mem [2*bmadp_pkg::MASK_COUNT];
	logic [VW-1:0]            aud_rd_q;
	logic [NP*VW-1:0]         skl_rd_q;
	bmadp_pkg::ord_t          ord_rd_q;
	logic [TW-1:0]            row_rd_q;
	logic [1:0][bmadp_pkg::MASK_COUNT-1:0] ok_q;

	// counters and working registers
	logic [CW-1:0]            cnt_q;
	logic                     drop_q;
	logic [CW-1:0]            i_q;
	logic [IW-1:0]            j_q;
	logic [VW-1:0]            vkey_q;
	logic [VW-1:0]            a_q;
	logic [NP-1:0][VW-1:0]    skill_q;
	logic                     bank_q;
	logic [MW-1:0]            m_q;
	logic [SW-1:0]            t_q;

	// update unit pipeline
	logic                     v_s1, ok_s1, first_s1, last_s1;
	logic [VW-1:0]            add_s1;
	logic [MW-1:0]            m_s1;
	logic [TW-1:0]            acc_q;
	logic                     acc_ok_q;

	logic                     res_valid_q;
	bmadp_pkg::res_t          res_q;

	// control
	logic                     take;
	logic                     ord_we;
	logic [IW-1:0]            ord_waddr, ord_raddr;
	bmadp_pkg::ord_t          ord_wdata;
	logic [IW-1:0]            aud_raddr, skl_raddr;
	logic [MW:0]              row_raddr;
	logic                     out_free;
	logic [SW-1:0]            p_eff;
	logic [MW-1:0]            mask_last;
	logic                     i_done;

	// issue side of the update unit
	logic [MW-1:0]            bitsel, iss_mask;
	logic                     iss_ok;
	logic [VW-1:0]            iss_add;
	logic [3:0]               pc;
	logic [CW:0]              free_lim;

	// update side
	logic [TW-1:0]            cand_sum, acc_new;
	logic                     acc_ok_new, upd;

	assign cfg_ready  = 1'b1;
	assign cand_stall = (state_q != bmadp_pkg::ST_IDLE);
	assign take       = cand_valid && !cand_stall;
	assign res_valid  = res_valid_q;
	assign res        = res_q;
	assign out_free   = !res_valid_q || !res_stall;
	assign p_eff      = SW'(npos_q);
	assign mask_last  = MW'((32'd1 << p_eff) - 32'd1);
	assign i_done     = (i_q + CW'(1)) == cnt_q;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			bmadp_pkg::ST_IDLE: begin
				if (take && cand.last) state_d = bmadp_pkg::ST_SORT_RD;
			end
			bmadp_pkg::ST_SORT_RD:  state_d = bmadp_pkg::ST_SORT_KEY;
			bmadp_pkg::ST_SORT_KEY: begin
				if (i_q == '0) state_d = i_done ? bmadp_pkg::ST_DP_INIT : bmadp_pkg::ST_SORT_RD;
				else state_d = bmadp_pkg::ST_SORT_CMP;
			end
			bmadp_pkg::ST_SORT_CMP: begin
				if (vkey_q < ord_rd_q.key)
					state_d = i_done ? bmadp_pkg::ST_DP_INIT : bmadp_pkg::ST_SORT_RD;
				else if (j_q == IW'(1)) state_d = bmadp_pkg::ST_SORT_PUT;
			end
			bmadp_pkg::ST_SORT_PUT:
				state_d = i_done ? bmadp_pkg::ST_DP_INIT : bmadp_pkg::ST_SORT_RD;
			bmadp_pkg::ST_DP_INIT:
				state_d = (cnt_q == '0) ? bmadp_pkg::ST_RES_RD : bmadp_pkg::ST_FETCH_ORD;
			bmadp_pkg::ST_FETCH_ORD: state_d = bmadp_pkg::ST_FETCH_ROW;
			bmadp_pkg::ST_FETCH_ROW: state_d = bmadp_pkg::ST_FETCH_SKL;
			bmadp_pkg::ST_FETCH_SKL: state_d = bmadp_pkg::ST_DP_RUN;
			bmadp_pkg::ST_DP_RUN: begin
				if (t_q == p_eff && m_q == mask_last) state_d = bmadp_pkg::ST_DP_DRAIN;
			end
			bmadp_pkg::ST_DP_DRAIN:
				state_d = i_done ? bmadp_pkg::ST_RES_RD : bmadp_pkg::ST_FETCH_ORD;
			bmadp_pkg::ST_RES_RD:  state_d = bmadp_pkg::ST_RES_OUT;
			bmadp_pkg::ST_RES_OUT: begin
				if (out_free) state_d = bmadp_pkg::ST_IDLE;
			end
			default: state_d = bmadp_pkg::ST_IDLE;
		endcase
	end

	// memory addressing and write controls
	always_comb begin
		ord_we    = 1'b0;
		ord_waddr = j_q;
		ord_wdata = '{key: vkey_q, idx: i_q[IW-1:0]};
		ord_raddr = i_q[IW-1:0];
		aud_raddr = i_q[IW-1:0];
		skl_raddr = ord_rd_q.idx;
		row_raddr = {bank_q, iss_mask};
		case (state_q)
			bmadp_pkg::ST_SORT_KEY: begin
				ord_raddr = i_q[IW-1:0] - IW'(1);
				if (i_q == '0) begin
					ord_we    = 1'b1;
					ord_waddr = '0;
					ord_wdata = '{key: aud_rd_q, idx: i_q[IW-1:0]};
				end
			end
			bmadp_pkg::ST_SORT_CMP: begin
				ord_we    = 1'b1;
				ord_raddr = j_q - IW'(2);
				if (vkey_q >= ord_rd_q.key) ord_wdata = ord_rd_q;
			end
			bmadp_pkg::ST_SORT_PUT: begin
				ord_we    = 1'b1;
				ord_waddr = '0;
			end
			bmadp_pkg::ST_RES_RD, bmadp_pkg::ST_RES_OUT: row_raddr = {bank_q, mask_last};
			default: ;
		endcase
	end

	// issue side: previous-row address, its valid bit and the value to add
	always_comb begin
		bitsel   = (t_q == '0) ? '0 : MW'(1) << (t_q - SW'(1));
		iss_mask = m_q ^ bitsel;
		iss_ok   = ok_q[bank_q][iss_mask] && ((t_q == '0) || ((m_q & bitsel) != '0));
		pc       = '0;
		for (int b = 0; b < MW; b++) pc = pc + 4'(m_q[b]);
		free_lim = (CW+1)'(kcnt_q) + (CW+1)'(pc);
		if (t_q == '0) iss_add = ((CW+1)'(i_q) < free_lim) ? a_q : '0;
		else iss_add = skill_q[t_q - SW'(1)];
	end

	// update side: one add and one compare a cycle
	always_comb begin
		cand_sum   = row_rd_q + TW'(add_s1);
		upd        = ok_s1 && (first_s1 || !acc_ok_q || (cand_sum > acc_q));
		acc_new    = upd ? cand_sum : (first_s1 ? '0 : acc_q);
		acc_ok_new = upd || (!first_s1 && acc_ok_q);
	end

	// memories
	always_ff @(posedge clk) begin
		if (take && cnt_q < CW'(bmadp_pkg::MAX_ITEMS)) begin
			aud_mem[cnt_q[IW-1:0]] <= cand.audience_strength;
			skl_mem[cnt_q[IW-1:0]] <= {cand.skill_6, cand.skill_5, cand.skill_4,
				cand.skill_3, cand.skill_2, cand.skill_1, cand.skill_0};
		end
		if (ord_we) ord_mem[ord_waddr] <= ord_wdata;
		if (state_q == bmadp_pkg::ST_DP_INIT) row_mem[{1'b0, MW'(0)}] <= '0;
		else if (v_s1 && last_s1) row_mem[{!bank_q, m_s1}] <= acc_new;
		aud_rd_q <= aud_mem[aud_raddr];
		skl_rd_q <= skl_mem[skl_raddr];
		ord_rd_q <= ord_mem[ord_raddr];
		row_rd_q <= row_mem[row_raddr];
	end

	// state, configuration and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= bmadp_pkg::ST_IDLE;
			npos_q      <= bmadp_pkg::P_W'(1);
			kcnt_q      <= '0;
			cnt_q       <= '0;
			drop_q      <= 1'b0;
			res_valid_q <= 1'b0;
			v_s1        <= 1'b0;
			ok_q        <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == bmadp_pkg::REG_NUM_POSITIONS)
					npos_q <= cfg_data[bmadp_pkg::P_W-1:0];
				else if (cfg_index == bmadp_pkg::REG_AUDIENCE_COUNT)
					kcnt_q <= cfg_data;
			end
			if (take) begin
				if (cnt_q < CW'(bmadp_pkg::MAX_ITEMS)) cnt_q <= cnt_q + CW'(1);
				else drop_q <= 1'b1;
			end
			if (state_q == bmadp_pkg::ST_RES_OUT && out_free) begin
				res_valid_q <= 1'b1;
				cnt_q       <= '0;
				drop_q      <= 1'b0;
			end else if (res_valid_q && !res_stall) begin
				res_valid_q <= 1'b0;
			end
			v_s1 <= (state_q == bmadp_pkg::ST_DP_RUN);
			if (state_q == bmadp_pkg::ST_DP_INIT) begin
				ok_q[0] <= bmadp_pkg::MASK_COUNT'(1);
			end else if (v_s1 && last_s1) begin
				ok_q[!bank_q][m_s1] <= acc_ok_new;
			end
		end
	end

	// working registers of sort and DP
	always_ff @(posedge clk) begin
		ok_s1    <= iss_ok;
		add_s1   <= iss_add;
		first_s1 <= (t_q == '0);
		last_s1  <= (t_q == p_eff);
		m_s1     <= m_q;
		if (v_s1) begin
			acc_q    <= acc_new;
			acc_ok_q <= acc_ok_new;
		end
		case (state_q)
			bmadp_pkg::ST_IDLE: i_q <= '0;
			bmadp_pkg::ST_SORT_KEY: begin
				vkey_q <= aud_rd_q;
				j_q    <= i_q[IW-1:0];
				if (i_q == '0) i_q <= i_q + CW'(1);
			end
			bmadp_pkg::ST_SORT_CMP: begin
				if (vkey_q < ord_rd_q.key) i_q <= i_q + CW'(1);
				else j_q <= j_q - IW'(1);
			end
			bmadp_pkg::ST_SORT_PUT: i_q <= i_q + CW'(1);
			bmadp_pkg::ST_DP_INIT: begin
				i_q    <= '0;
				bank_q <= 1'b0;
			end
			bmadp_pkg::ST_FETCH_ROW: a_q <= ord_rd_q.key;
			bmadp_pkg::ST_FETCH_SKL: begin
				skill_q <= skl_rd_q;
				m_q     <= '0;
				t_q     <= '0;
			end
			bmadp_pkg::ST_DP_RUN: begin
				if (t_q == p_eff) begin
					t_q <= '0;
					m_q <= m_q + MW'(1);
				end else begin
					t_q <= t_q + SW'(1);
				end
			end
			bmadp_pkg::ST_DP_DRAIN: begin
				bank_q <= !bank_q;
				i_q    <= i_q + CW'(1);
			end
			bmadp_pkg::ST_RES_OUT: begin
				if (out_free) begin
					res_q.best_total <= ok_q[bank_q][mask_last] ? $signed(row_rd_q) : -TW'(1);
					res_q.overflow   <= drop_q;
				end
			end
			default: ;
		endcase
	end

endmodule

FILE: src/bmadp_checker.sv
// ----------------------------------------------------------------------------
// bmadp_checker - port-level checks
// Watches the top level's channels for busy/result ordering and hold rules.
// ----------------------------------------------------------------------------
module bmadp_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             cand_valid,
	input logic             cand_stall,
	input bmadp_pkg::cand_t cand,
	input logic             res_valid,
	input logic             res_stall,
	input bmadp_pkg::res_t  res
);

	// a last item always sends the block busy
	a_last_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cand_valid && !cand_stall && cand.last |=> cand_stall)
		else $error("block took an item straight after a last item");

	// a new result only appears at the end of a busy period
	a_res_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid) |-> $past(cand_stall))
		else $error("result raised without a computation");

	// total is either unreachable or non-negative
	a_total_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (!res.best_total[bmadp_pkg::TOTAL_BITS-1] || res.best_total == -1))
		else $error("best total out of range");

	// stalled result holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(res))
		else $error("stalled result changed");

endmodule

bind bitmask_assignment_with_audience_dp bmadp_checker u_bmadp_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.cand_valid (cand_valid),
	.cand_stall (cand_stall),
	.cand       (cand),
	.res_valid  (res_valid),
	.res_stall  (res_stall),
	.res        (res)
);
